@@ hw/rtl/ots_pkg.sv @@
package ots_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int AW          = $clog2(MAX_ENTRIES);
    // Signed index width: covers -1 and the widest hunt bound (about 3x the table).
    localparam int PW          = AW + 3;

    localparam int KEY_W    = 32;
    localparam int IDX_W    = 6;
    localparam int LEN_W    = 7;
    localparam int POS_W    = 7;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 8;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(64);

    typedef logic signed [PW-1:0] t_pos;

    typedef enum logic {
        OPC_LOAD   = 1'b0,
        OPC_SEARCH = 1'b1
    } t_opcode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_T0,
        S_TL,
        S_CHK,
        S_HUP,
        S_HDN,
        S_BIS,
        S_FIX,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        RD_ZERO,
        RD_TOP,
        RD_LOW,
        RD_HIGH,
        RD_MID
    } t_rd_sel;

    typedef enum logic [2:0] {
        UPD_HOLD,
        UPD_INIT,
        UPD_UP_FIRST,
        UPD_UP_STEP,
        UPD_DN_STEP,
        UPD_BELOW,
        UPD_BIS,
        UPD_FIX
    } t_upd;

    typedef struct packed {
        logic    wr_entry;
        logic    ld_key;
        logic    ld_t0;
        logic    ld_tl;
        logic    rd_en;
        t_rd_sel rd_sel;
        t_upd    upd;
        logic    emit;
    } t_dp_cmd;

    typedef struct packed {
        logic cmp;
        logic stale;
        logic at_top;
        logic at_bottom;
        logic up_clip;
        logic dn_clip;
        logic bracketed;
        logic out_free;
    } t_dp_stat;

endpackage

@@ hw/rtl/ots_ram.sv @@
module ots_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/ots_ctrl.sv @@
module ots_ctrl import ots_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_opcode  i_opcode,
    output logic     o_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    t_state bis_entry;

    // Entering bisection: finish at once if the bracket is already one wide.
    assign bis_entry = i_stat.bracketed ? S_FIX : S_BIS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid && i_opcode == OPC_SEARCH) begin
                    n_state = S_T0;
                end
            end
            S_T0: n_state = S_TL;
            S_TL: n_state = i_stat.stale ? bis_entry : S_CHK;
            S_CHK: begin
                if (i_stat.cmp) begin
                    n_state = i_stat.at_top ? S_DONE : S_HUP;
                end else if (i_stat.at_bottom) begin
                    n_state = S_DONE;
                end else begin
                    n_state = i_stat.dn_clip ? bis_entry : S_HDN;
                end
            end
            S_HUP: begin
                if (i_stat.cmp && !i_stat.up_clip) begin
                    n_state = S_HUP;
                end else begin
                    n_state = bis_entry;
                end
            end
            S_HDN: begin
                if (!i_stat.cmp && !i_stat.dn_clip) begin
                    n_state = S_HDN;
                end else begin
                    n_state = bis_entry;
                end
            end
            S_BIS: n_state = bis_entry;
            S_FIX: n_state = S_DONE;
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_opcode == OPC_LOAD) begin
                        o_cmd.wr_entry = 1'b1;
                    end else begin
                        o_cmd.ld_key = 1'b1;
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = RD_ZERO;
                    end
                end
            end
            S_T0: begin
                o_cmd.ld_t0  = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_TOP;
            end
            S_TL: begin
                o_cmd.ld_tl  = 1'b1;
                o_cmd.upd    = UPD_INIT;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = i_stat.stale ? RD_MID : RD_LOW;
            end
            S_CHK: begin
                if (i_stat.cmp) begin
                    if (!i_stat.at_top) begin
                        o_cmd.upd    = UPD_UP_FIRST;
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = RD_HIGH;
                    end
                end else if (i_stat.at_bottom) begin
                    o_cmd.upd = UPD_BELOW;
                end else begin
                    o_cmd.upd    = UPD_DN_STEP;
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = i_stat.dn_clip ? RD_MID : RD_LOW;
                end
            end
            S_HUP: begin
                o_cmd.rd_en = 1'b1;
                if (i_stat.cmp) begin
                    o_cmd.upd    = UPD_UP_STEP;
                    o_cmd.rd_sel = i_stat.up_clip ? RD_MID : RD_HIGH;
                end else begin
                    o_cmd.rd_sel = RD_MID;
                end
            end
            S_HDN: begin
                o_cmd.rd_en = 1'b1;
                if (!i_stat.cmp) begin
                    o_cmd.upd    = UPD_DN_STEP;
                    o_cmd.rd_sel = i_stat.dn_clip ? RD_MID : RD_LOW;
                end else begin
                    o_cmd.rd_sel = RD_MID;
                end
            end
            S_BIS: begin
                o_cmd.upd    = UPD_BIS;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_MID;
            end
            S_FIX: o_cmd.upd = UPD_FIX;
            S_DONE: o_cmd.emit = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.out_free)
        else $error("result emitted while the output word is still held");

    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && i_valid && i_opcode == OPC_LOAD) |=> o_ready)
        else $error("a load word left the controller busy");

    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && i_valid && i_opcode == OPC_SEARCH) |=> (!o_ready && !o_cmd.emit))
        else $error("search word did not start the table walk");

endmodule

@@ hw/rtl/ots_datapath.sv @@
module ots_datapath import ots_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [LEN_W-1:0]        i_cfg_wr_data,
    input  logic [IDX_W-1:0]        i_entry_index,
    input  logic signed [KEY_W-1:0] i_key_value,
    input  t_dp_cmd                 i_cmd,
    output t_dp_stat                o_stat,
    output logic                    o_m_valid,
    input  logic                    i_m_ready,
    output logic signed [POS_W-1:0] o_position
);

    logic [LEN_W-1:0]        r_len;
    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] r_t0;
    logic signed [KEY_W-1:0] r_tl;
    logic                    r_asc;
    t_pos                    r_low;
    t_pos                    r_high;
    t_pos                    r_step;
    t_pos                    r_mid;
    t_pos                    r_last;
    logic                    r_out_valid;
    logic signed [POS_W-1:0] r_out_pos;

    t_pos n_low;
    t_pos n_high;
    t_pos n_step;
    t_pos n_mid;

    t_pos                    len_eff;
    t_pos                    top_idx;
    t_pos                    step2;
    t_pos                    up_reach;
    logic [KEY_W-1:0]        ram_rd_data;
    logic signed [KEY_W-1:0] rd_key;
    logic [AW-1:0]           rd_addr;
    logic                    wr_en;
    logic                    cmp;

    always_comb begin
        if (r_len < LEN_W'(2)) begin
            len_eff = t_pos'(2);
        end else if (int'(r_len) > MAX_ENTRIES) begin
            len_eff = t_pos'(MAX_ENTRIES);
        end else begin
            len_eff = t_pos'(r_len);
        end
    end

    assign top_idx  = len_eff - t_pos'(1);
    assign step2    = r_step <<< 1;
    assign up_reach = r_high + step2;
    assign rd_key   = signed'(ram_rd_data);

    // True if ascending and key >= entry read, or descending and key < it.
    assign cmp = ((r_key >= rd_key) == r_asc);

    always_comb begin
        n_low  = r_low;
        n_high = r_high;
        n_step = r_step;
        case (i_cmd.upd)
            UPD_HOLD: n_low = r_low;
            UPD_INIT: begin
                n_step = t_pos'(1);
                if (o_stat.stale) begin
                    n_low  = t_pos'(-1);
                    n_high = len_eff;
                end else begin
                    n_low  = r_last;
                    n_high = r_last;
                end
            end
            UPD_UP_FIRST: n_high = r_low + t_pos'(1);
            UPD_UP_STEP: begin
                n_low  = r_high;
                n_step = step2;
                n_high = o_stat.up_clip ? len_eff : up_reach;
            end
            UPD_DN_STEP: begin
                n_high = r_low;
                n_step = step2;
                n_low  = o_stat.dn_clip ? t_pos'(-1) : (r_low - step2);
            end
            UPD_BELOW: n_low = t_pos'(-1);
            UPD_BIS: begin
                if (cmp) begin
                    n_low = r_mid;
                end else begin
                    n_high = r_mid;
                end
            end
            UPD_FIX: begin
                // A match with entry 0 wins over a match with the last entry.
                if (r_key == r_t0) begin
                    n_low = t_pos'(0);
                end else if (r_key == r_tl) begin
                    n_low = len_eff - t_pos'(2);
                end
            end
            default: n_low = r_low;
        endcase
    end

    // The sum is never negative once the bracket is at least two wide.
    assign n_mid = (n_low + n_high) >>> 1;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_ZERO: rd_addr = '0;
            RD_TOP:  rd_addr = top_idx[AW-1:0];
            RD_LOW:  rd_addr = n_low[AW-1:0];
            RD_HIGH: rd_addr = n_high[AW-1:0];
            RD_MID:  rd_addr = n_mid[AW-1:0];
            default: rd_addr = '0;
        endcase
    end

    assign wr_en = i_cmd.wr_entry && (int'(i_entry_index) < MAX_ENTRIES);

    ots_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(i_entry_index)),
        .i_wr_data (i_key_value),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_comb begin
        o_stat.cmp       = cmp;
        o_stat.stale     = (r_last < t_pos'(0)) || (r_last > top_idx);
        o_stat.at_top    = (r_low == top_idx);
        o_stat.at_bottom = (r_low == t_pos'(0));
        o_stat.up_clip   = (up_reach > top_idx);
        o_stat.dn_clip   = (step2 >= r_low);
        o_stat.bracketed = ((n_high - n_low) == t_pos'(1));
        o_stat.out_free  = !r_out_valid || i_m_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= LEN_RESET;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_len <= i_cfg_wr_data;
            end
            if (i_cmd.emit) begin
                r_last      <= r_low;
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_low  <= n_low;
        r_high <= n_high;
        r_step <= n_step;
        r_mid  <= n_mid;
        if (i_cmd.ld_key) begin
            r_key <= i_key_value;
        end
        if (i_cmd.ld_t0) begin
            r_t0 <= rd_key;
        end
        if (i_cmd.ld_tl) begin
            r_tl  <= rd_key;
            r_asc <= (rd_key >= r_t0);
        end
        if (i_cmd.emit) begin
            r_out_pos <= POS_W'(r_low);
        end
    end

    assign o_m_valid  = r_out_valid;
    assign o_position = r_out_pos;

    a_bis_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.upd == UPD_BIS) |-> ((r_high - r_low) > t_pos'(1)))
        else $error("bisection step on a bracket that is already closed");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_low >= t_pos'(-1) && r_low <= top_idx))
        else $error("search answer lies outside the table");

    a_last_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_last == $past(r_low) && o_position == POS_W'($past(r_low))))
        else $error("start position and output word disagree after a search");

endmodule

@@ hw/rtl/ordered_table_hunt_search_unit.sv @@
// Load words give no result word.
// A search word walks the table through the single read port, at most one table read per
// cycle: two reads fetch the end entries, then come the hunt and bisection steps, which are
// skipped when the start position is at an end of the table and the key lies outward of it.
// A finished result waits in the output register while the next word is accepted.
// Reset (synchronous, active low) sets the table length to 64 and the start position to 0.
module ordered_table_hunt_search_unit import ots_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [LEN_W-1:0]    i_cfg_wr_data,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // [5:0] entry_index, [37:6] key_value, [39:38] zero
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,
    // [0] opcode
    input  logic                i_s_axis_tuser,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // [6:0] position, [7] zero
    output logic [M_DATA_W-1:0] o_m_axis_tdata
);

    t_dp_cmd                 cmd;
    t_dp_stat                stat;
    t_opcode                 opcode;
    logic signed [POS_W-1:0] position;

    assign opcode = t_opcode'(i_s_axis_tuser);

    ots_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_opcode (opcode),
        .o_ready  (o_s_axis_tready),
        .i_stat   (stat),
        .o_cmd    (cmd)
    );

    ots_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_entry_index (i_s_axis_tdata[IDX_W-1:0]),
        .i_key_value   (signed'(i_s_axis_tdata[IDX_W +: KEY_W])),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_m_valid     (o_m_axis_tvalid),
        .i_m_ready     (i_m_axis_tready),
        .o_position    (position)
    );

    assign o_m_axis_tdata = {{(M_DATA_W - POS_W){1'b0}}, position};

endmodule
